>>> rtl/interpolated_allpass_delay_assert.svh
// assertion macros used by interpolated_allpass_delay.sv
`ifndef INTERPOLATED_ALLPASS_DELAY_ASSERT_SVH
`define INTERPOLATED_ALLPASS_DELAY_ASSERT_SVH

`ifndef SYNTHESIS
`define IAD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IAD_ASSERT(label, prop, msg) \
  `IAD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define IAD_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define IAD_ASSERT(label, prop, msg)
`endif

`endif

>>> rtl/iad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iad_pkg;

  localparam int DEPTH       = 65536;
  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_W      = 18;
  localparam int DELAY_W     = 24;
  localparam int BL_W        = 17;
  localparam int CFG_W       = 24;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = ADDR_W + 1;
  localparam int POS_W  = LEN_W + 8;

  localparam logic [BL_W-1:0]    BUF_LEN_RST   = BL_W'(65536);
  localparam logic [DELAY_W-1:0] MAX_DELAY_RST = DELAY_W'(16776960);
  localparam logic [DELAY_W-1:0] ONE_SAMPLE    = DELAY_W'(256);

  // configuration register indexes
  localparam logic REG_BUFFER_LENGTH = 1'b0;
  localparam logic REG_MAX_DELAY     = 1'b1;

  // commands
  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

endpackage

`default_nettype wire

>>> rtl/iad_hist_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module iad_hist_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 24
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/interpolated_allpass_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// Schroeder allpass section with a fractional, linearly interpolated delay.
// Input channel (in_valid_i / in_stall_o) carries one transaction per sample:
// cmd_i selects process or clear, with sample_in_i (Q1.23), delay_i (Q16.8
// samples) and gain_i (Q2.16). Output channel (out_valid_o / out_stall_i)
// returns one sample_out_o per input transaction, in order; a clear returns 0.
// Configuration is a write port (cfg_we_i, cfg_idx_i, cfg_data_i): index 0 is
// buffer_length, index 1 is max_delay; write it only while the block is idle.
// A process transaction runs the limit, address, two read, interpolate,
// multiply and sum steps; the next is taken once the sequencer is idle. It
// uses both single-port history memories (two interpolation reads each, plus
// one write each) and two multiplier stages. A clear jumps to the sum step.
// Reset sets both registers to their defaults, the write position to zero and
// the fill count to zero; entries at or above the fill count read as zero, so
// no clearing pass is needed after reset or after a clear.
// A stalled result sits in the output register while the next transaction is
// taken and processed; the sequencer then holds in its last step until the
// output register frees up.

module interpolated_allpass_delay
  import iad_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  wire logic        [DELAY_W-1:0]     delay_i,
  input  wire logic signed [GAIN_W-1:0]      gain_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed      [SAMPLE_BITS-1:0] sample_out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic        [CFG_W-1:0]       cfg_data_i
);

  `include "interpolated_allpass_delay_assert.svh"

  localparam int SB     = SAMPLE_BITS;
  localparam int PROD_W = SB + 1 + GAIN_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SH_W   = ACC_W - 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_MUL,
    ST_SUM
  } state_e;

  function automatic logic signed [SB-1:0] lerp(input logic signed [SB-1:0] a,
                                                input logic signed [SB-1:0] b,
                                                input logic [7:0] f);
    logic signed [SB:0]   d;
    logic signed [SB+9:0] s;
    d = $signed({b[SB-1], b}) - $signed({a[SB-1], a});
    s = $signed({{2{a[SB-1]}}, a, 8'h00}) + d * $signed({1'b0, f})
        + $signed((SB+10)'(128));
    return s[SB+7:8];
  endfunction

  state_e state_q;

  logic [BL_W-1:0]    buf_len_q;
  logic [DELAY_W-1:0] max_delay_q;
  logic [ADDR_W-1:0]  wp_q;
  logic [LEN_W-1:0]   fill_q;
  logic               out_valid_q;
  logic [SB-1:0]      sample_out_q;

  // per-transaction work registers
  logic                     is_clr_q;
  logic [LEN_W-1:0]         len_q;
  logic [ADDR_W-1:0]        wps_q;
  logic signed [SB-1:0]     x_q;
  logic signed [GAIN_W-1:0] g_q;
  logic [DELAY_W-1:0]       d1_q;
  logic [POS_W-1:0]         d2_q;
  logic [ADDR_W-1:0]        i0_q;
  logic [ADDR_W-1:0]        i1_q;
  logic [7:0]               frac_q;
  logic signed [SB-1:0]     xa_q;
  logic signed [SB-1:0]     ya_q;
  logic signed [SB-1:0]     xd_q;
  logic signed [SB-1:0]     yd_q;
  logic signed [PROD_W-1:0] prod_q;

  logic [SB-1:0] in_rdata, out_rdata;

  logic               in_acc;
  logic               out_free;
  logic [LEN_W-1:0]   len_eff;
  logic [ADDR_W-1:0]  wp_use;
  logic [DELAY_W-1:0] d_lim;
  logic [POS_W-1:0]   top;
  logic [POS_W:0]     pos_diff;
  logic [POS_W-1:0]   pos;
  logic [ADDR_W-1:0]  i0;
  logic [LEN_W-1:0]   i0_inc;
  logic [ADDR_W-1:0]  i1;
  logic               v0, v1, fwd1;
  logic signed [SB-1:0]     xb, yb;
  logic signed [SB:0]       dyx;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SH_W-1:0]   shifted;
  logic [SB-1:0]            y_sat;
  logic [LEN_W-1:0]         wp_inc;

  logic              in_en, in_we, out_en, out_we;
  logic [ADDR_W-1:0] in_addr, out_addr;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = $signed(sample_out_q);

  always_comb begin
    if (32'(buf_len_q) < 32'd2) begin
      len_eff = LEN_W'(2);
    end else if (32'(buf_len_q) > 32'(DEPTH)) begin
      len_eff = LEN_W'(DEPTH);
    end else begin
      len_eff = LEN_W'(buf_len_q);
    end
  end

  // stale write position after the length was reduced
  assign wp_use = (LEN_W'(wp_q) >= len_eff) ? '0 : wp_q;

  always_comb begin
    d_lim = (delay_i > max_delay_q) ? max_delay_q : delay_i;
    if (d_lim < ONE_SAMPLE) begin
      d_lim = ONE_SAMPLE;
    end
  end

  assign top = {len_q - LEN_W'(1), 8'h00};

  // read position wraps once at most since the delay never exceeds the length
  assign pos_diff = {2'b00, wps_q, 8'h00} - {1'b0, d2_q};
  assign pos      = pos_diff[POS_W] ? pos_diff[POS_W-1:0] + {len_q, 8'h00}
                                    : pos_diff[POS_W-1:0];
  assign i0       = pos[ADDR_W+7:8];
  assign i0_inc   = {1'b0, i0} + LEN_W'(1);
  assign i1       = (i0_inc >= len_q) ? '0 : i0_inc[ADDR_W-1:0];

  // entries at or above the fill count were never written since clear
  assign v0   = (LEN_W'(i0_q) < fill_q);
  assign v1   = (LEN_W'(i1_q) < fill_q);
  assign fwd1 = (i1_q == wps_q);

  assign xb = fwd1 ? x_q : (v1 ? $signed(in_rdata) : '0);
  assign yb = v1 ? $signed(out_rdata) : '0;

  assign dyx = $signed({yd_q[SB-1], yd_q}) - $signed({x_q[SB-1], x_q});

  assign acc = $signed({{(ACC_W-SB-16){xd_q[SB-1]}}, xd_q, 16'h0000})
             + $signed({prod_q[PROD_W-1], prod_q})
             + $signed(ACC_W'(32768));
  assign shifted = acc[ACC_W-1:16];

  always_comb begin
    if (!shifted[SH_W-1] && (|shifted[SH_W-2:SB-1])) begin
      y_sat = {1'b0, {(SB-1){1'b1}}};
    end else if (shifted[SH_W-1] && !(&shifted[SH_W-2:SB-1])) begin
      y_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_sat = shifted[SB-1:0];
    end
  end

  assign wp_inc = LEN_W'(wps_q) + LEN_W'(1);

  always_comb begin
    in_en    = 1'b0;
    in_we    = 1'b0;
    in_addr  = i0_q;
    out_en   = 1'b0;
    out_we   = 1'b0;
    out_addr = i0_q;
    case (state_q)
      ST_RD0: begin
        in_en  = 1'b1;
        out_en = 1'b1;
      end
      ST_RD1: begin
        in_en    = 1'b1;
        out_en   = 1'b1;
        in_addr  = i1_q;
        out_addr = i1_q;
      end
      ST_INTERP: begin
        in_en   = 1'b1;
        in_we   = 1'b1;
        in_addr = wps_q;
      end
      ST_SUM: begin
        out_en   = out_free && !is_clr_q;
        out_we   = 1'b1;
        out_addr = wps_q;
      end
      default: begin
        in_en  = 1'b0;
        out_en = 1'b0;
      end
    endcase
  end

  iad_hist_ram #(
    .ADDR_W(ADDR_W),
    .DATA_W(SB)
  ) u_in_hist (
    .clk_i  (clk_i),
    .en_i   (in_en),
    .we_i   (in_we),
    .addr_i (in_addr),
    .wdata_i(x_q),
    .rdata_o(in_rdata)
  );

  iad_hist_ram #(
    .ADDR_W(ADDR_W),
    .DATA_W(SB)
  ) u_out_hist (
    .clk_i  (clk_i),
    .en_i   (out_en),
    .we_i   (out_we),
    .addr_i (out_addr),
    .wdata_i(y_sat),
    .rdata_o(out_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      buf_len_q    <= BUF_LEN_RST;
      max_delay_q  <= MAX_DELAY_RST;
      wp_q         <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
      sample_out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BUFFER_LENGTH: buf_len_q   <= cfg_data_i[BL_W-1:0];
          REG_MAX_DELAY:     max_delay_q <= cfg_data_i[DELAY_W-1:0];
          default:           buf_len_q   <= buf_len_q;
        endcase
      end
      // in the last step the output register is refilled below
      if (out_valid_q && !out_stall_i && (state_q != ST_SUM)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= (cmd_i == CMD_CLEAR) ? ST_SUM : ST_LIMIT;
          end
        end
        ST_LIMIT:  state_q <= ST_ADDR;
        ST_ADDR:   state_q <= ST_RD0;
        ST_RD0:    state_q <= ST_RD1;
        ST_RD1:    state_q <= ST_INTERP;
        ST_INTERP: state_q <= ST_MUL;
        ST_MUL:    state_q <= ST_SUM;
        ST_SUM: begin
          if (out_free) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            if (is_clr_q) begin
              sample_out_q <= '0;
              wp_q         <= '0;
              fill_q       <= '0;
            end else begin
              sample_out_q <= y_sat;
              wp_q         <= (wp_inc >= len_q) ? '0 : wp_inc[ADDR_W-1:0];
              if (LEN_W'(wps_q) == fill_q) begin
                fill_q <= fill_q + LEN_W'(1);
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          is_clr_q <= (cmd_i == CMD_CLEAR);
          len_q    <= len_eff;
          wps_q    <= wp_use;
          x_q      <= sample_in_i;
          g_q      <= gain_i;
          d1_q     <= d_lim;
        end
      end
      ST_LIMIT: begin
        d2_q <= (32'(d1_q) > 32'(top)) ? top : POS_W'(d1_q);
      end
      ST_ADDR: begin
        i0_q   <= i0;
        i1_q   <= i1;
        frac_q <= pos[7:0];
      end
      ST_RD1: begin
        xa_q <= v0 ? $signed(in_rdata) : '0;
        ya_q <= v0 ? $signed(out_rdata) : '0;
      end
      ST_INTERP: begin
        xd_q <= lerp(xa_q, xb, frac_q);
        yd_q <= lerp(ya_q, yb, frac_q);
      end
      ST_MUL: begin
        prod_q <= g_q * dyx;
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
  end

  `IAD_ASSERT(a_fill_covers_wp, (LEN_W'(wp_q) <= fill_q),
              "write position beyond fill count")
  `IAD_ASSERT(a_fill_depth, (fill_q <= LEN_W'(DEPTH)), "fill count exceeds depth")
  `IAD_ASSERT(a_idx_in_len,
              (state_q == ST_RD0) |-> ((LEN_W'(i0_q) < len_q) && (LEN_W'(i1_q) < len_q)),
              "read index outside length")
  `IAD_ASSERT(a_no_self_read, (state_q == ST_RD0) |-> (i0_q != wps_q),
              "first tap hits write position")
  `IAD_ASSERT(a_accept_busy, (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE),
              "accepted transaction left sequencer idle")

endmodule

`default_nettype wire
